FILE: hdl/ucd_pkg.sv
// Shared types, request and event codes, and the descriptor size table
// for the USB control event decoder. No dependencies.
`timescale 1ns / 1ps

package ucd_pkg;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_DESC_REPLY = 4'd1,
		ACT_STATUS     = 4'd2,
		ACT_SET_ADDR   = 4'd3,
		ACT_CONFIGURE  = 4'd4,
		ACT_BUS_RESET  = 4'd5,
		ACT_CONN_DONE  = 4'd6,
		ACT_BULK_DONE  = 4'd7,
		ACT_BULK_START = 4'd8
	} action_t;

	// bmRequestType class bits and standard bRequest codes
	localparam logic [7:0] REQ_CLASS_MASK        = 8'h60;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

	// descriptor types in the wValue high byte
	localparam logic [7:0] DESC_TYPE_DEVICE = 8'h01;
	localparam logic [7:0] DESC_TYPE_CONFIG = 8'h02;
	localparam logic [7:0] DESC_TYPE_STRING = 8'h03;
	localparam logic [7:0] STRING_INDEX_MAX = 8'h03;

	localparam logic [2:0] DESC_ID_DEVICE  = 3'd0;
	localparam logic [2:0] DESC_ID_CONFIG  = 3'd1;
	localparam logic [2:0] DESC_ID_STRING0 = 3'd2;

	// controller event codes
	localparam logic [4:0] EP_CONTROL        = 5'd0;
	localparam logic [4:0] EP_BULK_IN        = 5'd3;
	localparam logic [3:0] EP_EVT_SETUP_DONE = 4'd1;
	localparam logic [3:0] DEV_EVT_BUS_RESET = 4'd1;
	localparam logic [3:0] DEV_EVT_CONN_DONE = 4'd3;

	localparam logic [3:0] ENABLE_RESET      = 4'h3;
	localparam logic [3:0] ENABLE_CONFIGURED = 4'hB;

	typedef struct packed {
		logic        command;
		logic [31:0] event_word;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
	} item_t;

	typedef struct packed {
		logic       configured;
		logic       bulk_busy;
		logic [6:0] address;
		logic [3:0] enable;
	} dev_state_t;

	typedef struct packed {
		action_t    action;
		logic [2:0] descriptor_id;
		logic [6:0] reply_length;
	} decision_t;

	function automatic logic [6:0] desc_size(input logic [2:0] id);
		logic [6:0] size;
		case (id)
			3'd0:    size = 7'd18;
			3'd1:    size = 7'd75;
			3'd2:    size = 7'd4;
			3'd3:    size = 7'd10;
			3'd4:    size = 7'd44;
			3'd5:    size = 7'd22;
			default: size = 7'd0;
		endcase
		return size;
	endfunction

endpackage

FILE: hdl/ucd_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing; field widths follow the decoder's item and result.
`timescale 1ns / 1ps

interface ucd_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] event_word;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_length;

	modport source (output valid, command, event_word, request_type, request_code,
		request_value, request_length, input ready);
	modport sink (input valid, command, event_word, request_type, request_code,
		request_value, request_length, output ready);
endinterface

interface ucd_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [2:0] descriptor_id;
	logic [6:0] reply_length;
	logic [6:0] device_address;
	logic       is_configured;
	logic       bulk_in_busy;
	logic [3:0] endpoint_enable;

	modport source (output valid, action, descriptor_id, reply_length, device_address,
		is_configured, bulk_in_busy, endpoint_enable, input ready);
	modport sink (input valid, action, descriptor_id, reply_length, device_address,
		is_configured, bulk_in_busy, endpoint_enable, output ready);
endinterface

FILE: hdl/ucd_decode.sv
// Combinational decode of one item against the current device state:
// gives the action, descriptor selection and next state. Uses ucd_pkg.
`timescale 1ns / 1ps

module ucd_decode (
	input  ucd_pkg::item_t     item,
	input  ucd_pkg::dev_state_t cur,
	output ucd_pkg::dev_state_t nxt,
	output ucd_pkg::decision_t  decision
);
	import ucd_pkg::*;

	logic [4:0] ep_num;
	logic [3:0] ep_code;
	logic [3:0] dev_code;
	logic [7:0] dtype;
	logic [7:0] dindex;
	logic [2:0] desc_id;
	logic [6:0] size;

	assign ep_num   = item.event_word[5:1];
	assign ep_code  = item.event_word[9:6];
	assign dev_code = item.event_word[11:8];
	assign dtype    = item.request_value[15:8];
	assign dindex   = item.request_value[7:0];

	always_comb begin
		nxt                    = cur;
		decision.action        = ACT_NONE;
		decision.descriptor_id = 3'd0;
		decision.reply_length  = 7'd0;
		desc_id                = DESC_ID_DEVICE;
		size                   = 7'd0;
		if (item.command) begin
			if (cur.configured) begin
				nxt.bulk_busy   = 1'b1;
				decision.action = ACT_BULK_START;
			end
		end else if (item.event_word[0]) begin
			if (ep_num == EP_CONTROL && ep_code == EP_EVT_SETUP_DONE) begin
				if ((item.request_type & REQ_CLASS_MASK) != 8'h00) begin
					decision.action = ACT_STATUS;
				end else begin
					unique case (item.request_code)
						REQ_GET_DESCRIPTOR: begin
							decision.action = ACT_DESC_REPLY;
							if (dtype == DESC_TYPE_DEVICE) begin
								desc_id = DESC_ID_DEVICE;
							end else if (dtype == DESC_TYPE_CONFIG) begin
								desc_id = DESC_ID_CONFIG;
							end else if (dtype == DESC_TYPE_STRING &&
								dindex <= STRING_INDEX_MAX) begin
								desc_id = DESC_ID_STRING0 + {1'b0, dindex[1:0]};
							end else begin
								decision.action = ACT_STATUS;
							end
							size = desc_size(desc_id);
							if (decision.action == ACT_DESC_REPLY) begin
								decision.descriptor_id = desc_id;
								decision.reply_length  =
									(item.request_length < {9'd0, size}) ?
									item.request_length[6:0] : size;
							end
						end
						REQ_SET_ADDRESS: begin
							nxt.address     = item.request_value[6:0];
							decision.action = ACT_SET_ADDR;
						end
						REQ_SET_CONFIGURATION: begin
							nxt.configured  = 1'b1;
							nxt.enable      = ENABLE_CONFIGURED;
							decision.action = ACT_CONFIGURE;
						end
						default: decision.action = ACT_STATUS;
					endcase
				end
			end else if (ep_num == EP_BULK_IN) begin
				// any event on the bulk IN endpoint ends the transfer
				nxt.bulk_busy   = 1'b0;
				decision.action = ACT_BULK_DONE;
			end
		end else begin
			unique case (dev_code)
				DEV_EVT_BUS_RESET: begin
					nxt.configured  = 1'b0;
					nxt.bulk_busy   = 1'b0;
					nxt.enable      = ENABLE_RESET;
					decision.action = ACT_BUS_RESET;
				end
				DEV_EVT_CONN_DONE: begin
					nxt.configured  = 1'b0;
					nxt.bulk_busy   = 1'b0;
					decision.action = ACT_CONN_DONE;
				end
				default: decision.action = ACT_NONE;
			endcase
		end
	end

endmodule

FILE: hdl/usb_control_event_decoder.sv
// USB control event decoder: input register, decode, result register.
// Pipeline: two register stages; an accepted item waits in the input register
// and moves to the result register when that register is empty or being taken.
// Throughput: one item per cycle while results are taken; the device state loop
// closes through the decode logic, between the input register and the state registers.
// Reset: asynchronous, active low; clears the flags and address, sets the
// endpoint mask to endpoints 0 and 1, and empties both pipeline registers.
`timescale 1ns / 1ps

module usb_control_event_decoder (
	input logic          clk,
	input logic          arst_n,
	ucd_item_if.sink     item,
	ucd_result_if.source result
);
	import ucd_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	dev_state_t state_q;
	dev_state_t state_nxt;
	decision_t  decision;
	logic       valid_s2;
	decision_t  decision_s2;
	logic       advance;
	item_t      item_in;

	assign item_in = '{command: item.command, event_word: item.event_word,
		request_type: item.request_type, request_code: item.request_code,
		request_value: item.request_value, request_length: item.request_length};

	// move stage 1 into the result register when it is empty or being taken
	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;

	ucd_decode u_decode (
		.item     (item_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.decision (decision)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1           <= 1'b0;
			valid_s2           <= 1'b0;
			state_q.configured <= 1'b0;
			state_q.bulk_busy  <= 1'b0;
			state_q.address    <= 7'd0;
			state_q.enable     <= ENABLE_RESET;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item_in;
		end
		if (advance && valid_s1) begin
			decision_s2 <= decision;
		end
	end

	// the result register holds the decision; state is the live snapshot,
	// which cannot move while the result waits
	assign result.valid           = valid_s2;
	assign result.action          = decision_s2.action;
	assign result.descriptor_id   = decision_s2.descriptor_id;
	assign result.reply_length    = decision_s2.reply_length;
	assign result.device_address  = state_q.address;
	assign result.is_configured   = state_q.configured;
	assign result.bulk_in_busy    = state_q.bulk_busy;
	assign result.endpoint_enable = state_q.enable;

	a_no_desc_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.action != ACT_DESC_REPLY) |->
		(result.descriptor_id == 3'd0 && result.reply_length == 7'd0))
		else $error("descriptor fields set without a descriptor reply");

	a_bulk_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.action == ACT_BULK_START) |->
		(result.is_configured && result.bulk_in_busy))
		else $error("bulk start without configured and busy state");

	a_bus_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.action == ACT_BUS_RESET) |->
		(!result.is_configured && !result.bulk_in_busy &&
		result.endpoint_enable == ENABLE_RESET))
		else $error("bus reset left device state set");

	a_state_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |=> $stable(state_q))
		else $error("device state moved under a stalled result");

endmodule
